FILE: rtl/assert_macros.svh
// Assertion macros for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error("assertion failed");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

FILE: rtl/mpm_pkg.sv
// Package for the message port matcher: codes, states and defaults.
`default_nettype none
package mpm_pkg;
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int ID_BITS_DEF = 8;
    localparam logic [31:0] MATCH_ALL_RESET = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {OP_SEND = 2'd0, OP_RECV = 2'd1, OP_FILT = 2'd2, OP_RESET = 2'd3}
        op_t;
    typedef enum logic [1:0] {EV_STATUS = 2'd0, EV_PAIR = 2'd1, EV_SFLUSH = 2'd2,
        EV_RFLUSH = 2'd3} event_t;
    typedef enum logic [2:0] {ST_OK = 3'd0, ST_NO_MSG = 3'd1, ST_ABORTED = 3'd2,
        ST_TIMEOUT = 3'd3, ST_FULL = 3'd4} status_t;

    typedef enum logic [3:0] {
        S_IDLE,     // waiting for start
        S_SCAN,     // read issued for idx_reg, data arrives next cycle
        S_SCAN_CHK, // compare read data
        S_FILT_SCAN,// filter change: second scan over senders
        S_FILT_CHK,
        S_SHIFT_RD, // compaction/insert shift: read
        S_SHIFT_WR, // write shifted entry
        S_PAIR,     // emit pairing
        S_FLUSH_RD,
        S_FLUSH_EM,
        S_DONE      // emit final status
    } state_t;
endpackage
`default_nettype wire

FILE: rtl/message_port_matcher_top.sv
// Message port matcher: sender and receiver queues in RAM with a sequencer.
// Usage: pulse start with a request's fields while busy is low; the block raises busy
// and reports results on the result ports, each marked by strobe for one
// cycle; the final result of a request is the status and carries last = 1. busy falls
// in the cycle after that result. Results cannot be held off by the receiver.
// Configuration: cfg_we writes match_all_pattern from cfg_wdata; the user must do
// so only while idle, as the block itself does not enforce it. Each request walks
// the queue it searches, entry by entry, through the RAM of that queue (registered
// read). Removing from the middle or inserting at the front shifts the tail, one
// moved entry at a time. A reset request reports each entry of each flushed queue
// in turn, then the status.
// Reset: rst_n clears both counts, so both queues are empty; queue RAMs are not cleared.
`default_nettype none
`include "assert_macros.svh"
module message_port_matcher_top #(
    parameter int QUEUE_DEPTH = mpm_pkg::QUEUE_DEPTH_DEF,
    parameter int ID_BITS = mpm_pkg::ID_BITS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [31:0]        cfg_wdata,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [1:0]         operation,
    input  wire logic [7:0]         msg_id,
    input  wire logic [31:0]        msg_type,
    input  wire logic [31:0]        filter,
    input  wire logic               urgent,
    input  wire logic               no_wait,
    input  wire logic               flush_senders,
    input  wire logic               flush_receivers,
    input  wire logic               abort_senders,
    input  wire logic               abort_receivers,
    output logic                    strobe,
    output logic [1:0]              event_kind,
    output logic [7:0]              receiver_id,
    output logic [7:0]              sender_id,
    output logic [31:0]             delivered_type,
    output logic [2:0]              status,
    output logic                    last
);
    localparam int IW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int EW = ID_BITS + 32;

    // queue memories: q 0 = senders, 1 = receivers
    logic [EW-1:0] smem [QUEUE_DEPTH];
    logic [EW-1:0] rmem [QUEUE_DEPTH];
    logic [EW-1:0] s_rd, r_rd;
    logic          mem_we, mem_q;
    logic [IW-1:0] mem_waddr, mem_raddr;
    logic [EW-1:0] mem_wdata;

    always_ff @(posedge clk)
    begin
        if (mem_we && !mem_q) smem[mem_waddr] <= mem_wdata;
        if (mem_we && mem_q) rmem[mem_waddr] <= mem_wdata;
        s_rd <= smem[mem_raddr];
        r_rd <= rmem[mem_raddr];
    end

    mpm_pkg::state_t state_reg, state_next;
    logic [31:0]     match_all_reg;
    logic [CW-1:0]   scount_reg, scount_next, rcount_reg, rcount_next;
    logic [CW-1:0]   idx_reg, idx_next;     // scan/shift position
    logic [CW-1:0]   end_reg, end_next;     // shift stop
    logic [CW-1:0]   hit_reg, hit_next;     // receiver index on filter change
    logic            q_reg, q_next;         // queue being worked on
    logic            up_reg, up_next;       // 1: shift toward higher index (insert)
    logic [1:0]      op_reg;
    logic [ID_BITS-1:0] id_reg;
    logic [31:0]     type_reg, filt_reg;
    logic            urg_reg, nw_reg, flr_reg, abs_reg, abr_reg;
    logic [ID_BITS-1:0] pid_reg, pid_next; // paired partner id
    logic [31:0]     ptype_reg, ptype_next;
    logic [EW-1:0]   hold_reg, hold_next;   // entry to write after shift
    logic [2:0]      st_reg, st_next;
    logic            pend_reg, pend_next;   // pairing to report after shift
    logic            rmv2_reg, rmv2_next;   // filter change: remove receiver next

    logic [EW-1:0] rd;
    logic [31:0]   rd_val;
    logic [ID_BITS-1:0] rd_id;
    assign rd = q_reg ? r_rd : s_rd;
    assign rd_val = rd[31:0];
    assign rd_id = rd[EW-1:32];

    function automatic logic acc(input logic [31:0] f, input logic [31:0] t,
                                 input logic [31:0] ma);
        return (f == ma) || ((f & t) != 32'd0);
    endfunction

    assign busy = (state_reg != mpm_pkg::S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mpm_pkg::S_IDLE;
            match_all_reg <= mpm_pkg::MATCH_ALL_RESET;
            scount_reg <= '0;
            rcount_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            scount_reg <= scount_next;
            rcount_reg <= rcount_next;
            if (cfg_we) match_all_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next; end_reg <= end_next; hit_reg <= hit_next;
        q_reg <= q_next; up_reg <= up_next; pid_reg <= pid_next;
        ptype_reg <= ptype_next; hold_reg <= hold_next; st_reg <= st_next;
        pend_reg <= pend_next; rmv2_reg <= rmv2_next;
        if (start && !busy)
        begin
            op_reg <= operation; id_reg <= ID_BITS'(msg_id);
            type_reg <= msg_type; filt_reg <= filter; urg_reg <= urgent;
            nw_reg <= no_wait; flr_reg <= flush_receivers;
            abs_reg <= abort_senders; abr_reg <= abort_receivers;
        end
    end

    logic [CW-1:0] cnt_q;
    assign cnt_q = q_reg ? rcount_reg : scount_reg;

    // next state and datapath updates
    always_comb
    begin
        state_next = state_reg;
        scount_next = scount_reg; rcount_next = rcount_reg;
        idx_next = idx_reg; end_next = end_reg; hit_next = hit_reg;
        q_next = q_reg; up_next = up_reg; pid_next = pid_reg;
        ptype_next = ptype_reg; hold_next = hold_reg; st_next = st_reg;
        pend_next = pend_reg; rmv2_next = rmv2_reg;
        case (state_reg)
            mpm_pkg::S_IDLE:
                if (start)
                begin
                    idx_next = '0; pend_next = 1'b0; rmv2_next = 1'b0; st_next = mpm_pkg::ST_OK;
                    case (mpm_pkg::op_t'(operation))
                        mpm_pkg::OP_SEND: begin q_next = 1'b1; state_next = mpm_pkg::S_SCAN; end
                        mpm_pkg::OP_RECV: begin q_next = 1'b0; state_next = mpm_pkg::S_SCAN; end
                        mpm_pkg::OP_FILT: begin q_next = 1'b1; state_next = mpm_pkg::S_SCAN; end
                        default:
                        begin
                            q_next = !flush_senders;
                            state_next = (flush_senders || flush_receivers)
                                ? mpm_pkg::S_FLUSH_RD : mpm_pkg::S_DONE;
                        end
                    endcase
                end
            mpm_pkg::S_SCAN:
                if (idx_reg >= cnt_q)
                begin
                    // nothing found
                    case (mpm_pkg::op_t'(op_reg))
                        mpm_pkg::OP_FILT: begin st_next = mpm_pkg::ST_NO_MSG;
                            state_next = mpm_pkg::S_DONE; end
                        mpm_pkg::OP_RECV:
                            if (nw_reg) begin st_next = mpm_pkg::ST_NO_MSG;
                                state_next = mpm_pkg::S_DONE; end
                            else if (rcount_reg == CW'(QUEUE_DEPTH)) begin
                                st_next = mpm_pkg::ST_FULL; state_next = mpm_pkg::S_DONE; end
                            else begin
                                q_next = 1'b1; hold_next = {id_reg, filt_reg};
                                up_next = 1'b1; idx_next = rcount_reg;
                                end_next = urg_reg ? '0 : rcount_reg;
                                state_next = mpm_pkg::S_SHIFT_RD; end
                        default:
                            if (scount_reg == CW'(QUEUE_DEPTH)) begin
                                st_next = mpm_pkg::ST_FULL; state_next = mpm_pkg::S_DONE; end
                            else begin
                                q_next = 1'b0; hold_next = {id_reg, type_reg};
                                up_next = 1'b1; idx_next = scount_reg;
                                end_next = urg_reg ? '0 : scount_reg;
                                state_next = mpm_pkg::S_SHIFT_RD; end
                    endcase
                end
                else
                    state_next = mpm_pkg::S_SCAN_CHK;
            mpm_pkg::S_SCAN_CHK:
            begin
                state_next = mpm_pkg::S_SCAN;
                idx_next = idx_reg + 1'b1;
                case (mpm_pkg::op_t'(op_reg))
                    mpm_pkg::OP_SEND:
                        if (acc(rd_val, type_reg, match_all_reg)) begin
                            pid_next = rd_id; ptype_next = type_reg; pend_next = 1'b1;
                            up_next = 1'b0; end_next = rcount_reg - 1'b1;
                            rcount_next = rcount_reg - 1'b1; idx_next = idx_reg;
                            state_next = mpm_pkg::S_SHIFT_RD; end
                    mpm_pkg::OP_RECV:
                        if (acc(filt_reg, rd_val, match_all_reg)) begin
                            pid_next = rd_id; ptype_next = rd_val; pend_next = 1'b1;
                            up_next = 1'b0; end_next = scount_reg - 1'b1;
                            scount_next = scount_reg - 1'b1; idx_next = idx_reg;
                            state_next = mpm_pkg::S_SHIFT_RD; end
                    default:
                        if (rd_id == id_reg) begin
                            hit_next = idx_reg; idx_next = '0; q_next = 1'b0;
                            state_next = mpm_pkg::S_FILT_SCAN; end
                endcase
            end
            mpm_pkg::S_FILT_SCAN:
                if (idx_reg >= scount_reg)
                begin
                    // rewrite the receiver filter, no pairing
                    q_next = 1'b1; hold_next = {id_reg, filt_reg};
                    up_next = 1'b1; idx_next = hit_reg; end_next = hit_reg;
                    state_next = mpm_pkg::S_SHIFT_RD;
                end
                else
                    state_next = mpm_pkg::S_FILT_CHK;
            mpm_pkg::S_FILT_CHK:
            begin
                idx_next = idx_reg + 1'b1;
                state_next = mpm_pkg::S_FILT_SCAN;
                if (acc(filt_reg, rd_val, match_all_reg))
                begin
                    pid_next = rd_id; ptype_next = rd_val; pend_next = 1'b1;
                    rmv2_next = 1'b1; up_next = 1'b0; end_next = scount_reg - 1'b1;
                    scount_next = scount_reg - 1'b1; idx_next = idx_reg;
                    state_next = mpm_pkg::S_SHIFT_RD;
                end
            end
            mpm_pkg::S_SHIFT_RD:
                // down: idx <- idx+1 until end; up: idx <- idx-1 down to end
                if (up_reg ? (idx_reg == end_reg) : (idx_reg >= end_reg))
                begin
                    if (up_reg)
                    begin
                        state_next = mpm_pkg::S_SHIFT_WR;
                    end
                    else if (rmv2_reg)
                    begin
                        rmv2_next = 1'b0; q_next = 1'b1; idx_next = hit_reg;
                        end_next = rcount_reg - 1'b1; rcount_next = rcount_reg - 1'b1;
                    end
                    else
                        state_next = pend_reg ? mpm_pkg::S_PAIR : mpm_pkg::S_DONE;
                end
                else
                    state_next = mpm_pkg::S_SHIFT_WR;
            mpm_pkg::S_SHIFT_WR:
                if (up_reg && idx_reg == end_reg)
                begin
                    // final write of the new entry
                    if (!(op_reg == mpm_pkg::OP_FILT))
                    begin
                        if (q_reg) rcount_next = rcount_reg + 1'b1;
                        else scount_next = scount_reg + 1'b1;
                    end
                    state_next = mpm_pkg::S_DONE;
                end
                else
                begin
                    idx_next = up_reg ? idx_reg - 1'b1 : idx_reg + 1'b1;
                    state_next = mpm_pkg::S_SHIFT_RD;
                end
            mpm_pkg::S_PAIR:
                state_next = mpm_pkg::S_DONE;
            mpm_pkg::S_FLUSH_RD:
                if (idx_reg >= cnt_q)
                begin
                    if (!q_reg) scount_next = '0; else rcount_next = '0;
                    idx_next = '0;
                    if (!q_reg && flr_reg) q_next = 1'b1;
                    else state_next = mpm_pkg::S_DONE;
                end
                else
                    state_next = mpm_pkg::S_FLUSH_EM;
            mpm_pkg::S_FLUSH_EM:
            begin
                idx_next = idx_reg + 1'b1;
                state_next = mpm_pkg::S_FLUSH_RD;
            end
            mpm_pkg::S_DONE:
                state_next = mpm_pkg::S_IDLE;
            default:
                state_next = mpm_pkg::S_IDLE;
        endcase
    end

    // memory port control
    always_comb
    begin
        mem_we = 1'b0; mem_q = q_reg; mem_waddr = idx_reg[IW-1:0];
        mem_wdata = hold_reg; mem_raddr = idx_reg[IW-1:0];
        case (state_reg)
            mpm_pkg::S_IDLE:
                mem_raddr = '0;
            mpm_pkg::S_SHIFT_RD:
                // read the neighbour that moves into idx
                mem_raddr = up_reg ? IW'(idx_reg - 1'b1) : IW'(idx_reg + 1'b1);
            mpm_pkg::S_SHIFT_WR:
            begin
                mem_we = 1'b1;
                if (!(up_reg && idx_reg == end_reg)) mem_wdata = rd;
            end
            default: ;
        endcase
    end

    // result outputs
    always_comb
    begin
        strobe = 1'b0; event_kind = mpm_pkg::EV_STATUS; receiver_id = '0; sender_id = '0;
        delivered_type = '0; status = mpm_pkg::ST_OK; last = 1'b0;
        case (state_reg)
            mpm_pkg::S_PAIR:
            begin
                strobe = 1'b1; event_kind = mpm_pkg::EV_PAIR;
                delivered_type = ptype_reg;
                if (op_reg == mpm_pkg::OP_SEND)
                begin
                    receiver_id = 8'(pid_reg); sender_id = 8'(id_reg);
                end
                else
                begin
                    receiver_id = 8'(id_reg); sender_id = 8'(pid_reg);
                end
            end
            mpm_pkg::S_FLUSH_EM:
            begin
                strobe = 1'b1;
                if (q_reg)
                begin
                    event_kind = mpm_pkg::EV_RFLUSH; receiver_id = 8'(rd_id);
                    status = abr_reg ? mpm_pkg::ST_ABORTED : mpm_pkg::ST_TIMEOUT;
                end
                else
                begin
                    event_kind = mpm_pkg::EV_SFLUSH; sender_id = 8'(rd_id);
                    status = abs_reg ? mpm_pkg::ST_ABORTED : mpm_pkg::ST_TIMEOUT;
                end
            end
            mpm_pkg::S_DONE:
            begin
                strobe = 1'b1; status = st_reg; last = 1'b1;
            end
            default: ;
        endcase
    end

    `ASSERT_CLK(a_scount_range, clk, rst_n, scount_reg <= CW'(QUEUE_DEPTH))
    `ASSERT_CLK(a_rcount_range, clk, rst_n, rcount_reg <= CW'(QUEUE_DEPTH))
    `ASSERT_NEXT(a_last_idle, clk, rst_n, strobe && last, !busy)
    `ASSERT_CLK(a_last_ends, clk, rst_n, !(strobe && last) || state_reg == mpm_pkg::S_DONE)
endmodule
`default_nettype wire
